>>> design/red_pkg.sv
// Shared types, constants and the half-step transition table of the rotary encoder decoder.
package red_pkg;

   localparam int unsigned TIME_BITS_DEFAULT = 32;
   localparam int unsigned NOW_MS_WIDTH      = 32;
   localparam int unsigned CFG_WIDTH         = 16;
   localparam int unsigned CSR_INDEX_WIDTH   = 3;

   // Register reset values in milliseconds
   localparam logic [CFG_WIDTH-1:0] MOVE_DEBOUNCE_RESET       = 16'd2;
   localparam logic [CFG_WIDTH-1:0] CLICK_QUIET_RESET         = 16'd70;
   localparam logic [CFG_WIDTH-1:0] CLICK_EXPIRE_RESET        = 16'd800;
   localparam logic [CFG_WIDTH-1:0] CLICK_EDGE_DEBOUNCE_RESET = 16'd80;
   localparam logic [CFG_WIDTH-1:0] CLICK_MIN_INTERVAL_RESET  = 16'd280;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MOVE_DEBOUNCE       = 3'd0,
      CSR_CLICK_QUIET         = 3'd1,
      CSR_CLICK_EXPIRE        = 3'd2,
      CSR_CLICK_EDGE_DEBOUNCE = 3'd3,
      CSR_CLICK_MIN_INTERVAL  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ACTION_NONE  = 2'd0,
      ACTION_UP    = 2'd1,
      ACTION_DOWN  = 2'd2,
      ACTION_CLICK = 2'd3
   } action_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] move_debounce_ms;
      logic [CFG_WIDTH-1:0] click_quiet_ms;
      logic [CFG_WIDTH-1:0] click_expire_ms;
      logic [CFG_WIDTH-1:0] click_edge_debounce_ms;
      logic [CFG_WIDTH-1:0] click_min_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic                    pin_a;
      logic                    pin_b;
      logic                    click_edge;
      logic [NOW_MS_WIDTH-1:0] now_ms;
   } poll_type;

   typedef struct packed {
      action_type              action;
      logic [NOW_MS_WIDTH-1:0] scroll_time;
   } result_type;

   // Table entry: direction in [5:4], next state in [2:0]
   typedef logic [5:0] hs_entry_type;

   localparam logic [1:0] HS_DIR_CW  = 2'b01;
   localparam logic [1:0] HS_DIR_CCW = 2'b10;
   localparam logic [2:0] HS_STATE_START = 3'd0;
   localparam logic [2:0] HS_STATE_LAST  = 3'd5;

   localparam hs_entry_type HS_TABLE [6][4] = '{
      '{6'h03, 6'h02, 6'h01, 6'h00},
      '{6'h23, 6'h00, 6'h01, 6'h00},
      '{6'h13, 6'h02, 6'h00, 6'h00},
      '{6'h03, 6'h05, 6'h04, 6'h00},
      '{6'h03, 6'h03, 6'h04, 6'h10},
      '{6'h03, 6'h05, 6'h03, 6'h20}
   };

   // Out-of-range states read as the start state
   function automatic hs_entry_type hs_lookup(input logic [2:0] state,
                                              input logic pin_a, input logic pin_b);
      logic [2:0] row;
      row = (state > HS_STATE_LAST) ? HS_STATE_START : state;
      return HS_TABLE[row][{pin_b, pin_a}];
   endfunction

endpackage

>>> design/red_ifs.sv
// Handshake channel interfaces for poll words, result words and register writes.
interface red_req_if import red_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    pin_a;
   logic                    pin_b;
   logic                    click_edge;
   logic [NOW_MS_WIDTH-1:0] now_ms;

   modport source (output valid, pin_a, pin_b, click_edge, now_ms, input ready);
   modport sink   (input valid, pin_a, pin_b, click_edge, now_ms, output ready);
endinterface

interface red_rsp_if import red_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              action;
   logic [NOW_MS_WIDTH-1:0] scroll_time;

   modport source (output valid, action, scroll_time, input ready);
   modport sink   (input valid, action, scroll_time, output ready);
endinterface

interface red_csr_if import red_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CFG_WIDTH-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/red_csr_regs.sv
// Configuration register file of the rotary encoder decoder.
module red_csr_regs import red_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   red_csr_if.sink      csr_ch,
   output cfg_type      cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_MOVE_DEBOUNCE:       cfg_in.move_debounce_ms       = csr_ch.data;
            CSR_CLICK_QUIET:         cfg_in.click_quiet_ms         = csr_ch.data;
            CSR_CLICK_EXPIRE:        cfg_in.click_expire_ms        = csr_ch.data;
            CSR_CLICK_EDGE_DEBOUNCE: cfg_in.click_edge_debounce_ms = csr_ch.data;
            CSR_CLICK_MIN_INTERVAL:  cfg_in.click_min_interval_ms  = csr_ch.data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.move_debounce_ms       <= MOVE_DEBOUNCE_RESET;
         cfg_ff.click_quiet_ms         <= CLICK_QUIET_RESET;
         cfg_ff.click_expire_ms        <= CLICK_EXPIRE_RESET;
         cfg_ff.click_edge_debounce_ms <= CLICK_EDGE_DEBOUNCE_RESET;
         cfg_ff.click_min_interval_ms  <= CLICK_MIN_INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/red_engine.sv
// Decoder state and the per-word step logic: table walk, scroll debounce, click arbitration.
module red_engine import red_pkg::*; #(
   parameter int unsigned TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  cfg_type    cfg,
   input  poll_type   poll,
   output result_type result
);

   typedef logic [TIME_BITS-1:0] time_type;

   logic [2:0] quad_ff, quad_in;
   logic       primed_ff;
   logic       pend_ff, pend_in;
   time_type   pend_time_ff, pend_time_in;
   time_type   seen_ff, seen_in;
   time_type   emit_ff, emit_in;
   time_type   move_ff, move_in;
   time_type   scroll_ff, scroll_in;

   time_type     now_t;
   logic [2:0]   quad_base;
   logic         pend_base;
   time_type     pend_time_base, seen_base, emit_base, move_base;
   logic         edge_ok;
   logic         pend_mid;
   hs_entry_type prime_entry, step_entry;
   logic [1:0]   dir;
   logic         move_ok;
   action_type   action;

   function automatic time_type elapsed(input time_type later, input time_type earlier);
      return later - earlier;
   endfunction

   assign now_t = time_type'(poll.now_ms);

   // First word: prime the table from the start state and stamp the move time
   assign prime_entry    = hs_lookup(HS_STATE_START, poll.pin_a, poll.pin_b);
   assign quad_base      = primed_ff ? quad_ff : prime_entry[2:0];
   assign pend_base      = primed_ff & pend_ff;
   assign pend_time_base = primed_ff ? pend_time_ff : '0;
   assign seen_base      = primed_ff ? seen_ff : '0;
   assign emit_base      = primed_ff ? emit_ff : '0;
   assign move_base      = primed_ff ? move_ff : now_t;

   assign edge_ok = poll.click_edge &
                    (elapsed(now_t, seen_base) >= time_type'(cfg.click_edge_debounce_ms));
   assign pend_mid     = pend_base | edge_ok;
   assign pend_time_in = edge_ok ? now_t : pend_time_base;
   assign seen_in      = edge_ok ? now_t : seen_base;

   assign step_entry = hs_lookup(quad_base, poll.pin_a, poll.pin_b);
   assign dir        = step_entry[5:4];
   assign quad_in    = step_entry[2:0];
   assign move_ok    = ((dir == HS_DIR_CW) || (dir == HS_DIR_CCW)) &
                       (elapsed(now_t, move_base) >= time_type'(cfg.move_debounce_ms));

   // Scroll wins over a pending click; a click left waiting may expire
   always_comb begin
      action    = ACTION_NONE;
      pend_in   = pend_mid;
      emit_in   = emit_base;
      move_in   = move_base;
      scroll_in = scroll_ff;
      if (move_ok) begin
         move_in   = now_t;
         scroll_in = now_t;
         action    = (dir == HS_DIR_CW) ? ACTION_UP : ACTION_DOWN;
      end else if (pend_mid &&
                   (elapsed(now_t, scroll_ff) >= time_type'(cfg.click_quiet_ms))) begin
         pend_in = 1'b0;
         if (elapsed(now_t, emit_base) >= time_type'(cfg.click_min_interval_ms)) begin
            emit_in = now_t;
            action  = ACTION_CLICK;
         end
      end else if (pend_mid &&
                   (elapsed(now_t, pend_time_in) > time_type'(cfg.click_expire_ms))) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_ff      <= HS_STATE_START;
         primed_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         pend_time_ff <= '0;
         seen_ff      <= '0;
         emit_ff      <= '0;
         move_ff      <= '0;
         scroll_ff    <= '0;
      end else if (step_en) begin
         quad_ff      <= quad_in;
         primed_ff    <= 1'b1;
         pend_ff      <= pend_in;
         pend_time_ff <= pend_time_in;
         seen_ff      <= seen_in;
         emit_ff      <= emit_in;
         move_ff      <= move_in;
         scroll_ff    <= scroll_in;
      end
   end

   assign result.action      = action;
   assign result.scroll_time = NOW_MS_WIDTH'(scroll_in);

endmodule

>>> design/rotary_encoder_half_step_decoder_core.sv
// Throughput: one word per cycle while rsp_ready is high.
// The step logic is a single table-walk and compare pass.
// An input register and a result register sit between the channels; while a result word
// waits, one more poll word is still captured, after which req_ready drops.
// Reset: synchronous, active high; clears decoder state and loads register defaults.
// Registers are written at any time with csr_ready held high; write them only when idle.
module rotary_encoder_half_step_decoder_core import red_pkg::*; #(
   parameter int unsigned TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   red_req_if.sink  req_ch,
   red_rsp_if.source rsp_ch,
   red_csr_if.sink  csr_ch
);

   cfg_type    cfg;
   result_type step_result;

   // Input stage
   logic       in_valid_ff;
   poll_type   in_word_ff;
   logic       in_advance;

   // Result stage
   logic       out_valid_ff;
   result_type out_word_ff;
   logic       out_free;

   red_csr_regs u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // Advance the input word into the result register whenever that register is free;
   // decoder state updates on the same edge.
   assign out_free   = !out_valid_ff || rsp_ch.ready;
   assign in_advance = in_valid_ff && out_free;

   red_engine #(
      .TIME_BITS (TIME_BITS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (in_advance),
      .cfg     (cfg),
      .poll    (in_word_ff),
      .result  (step_result)
   );

   // Accept a new poll word when the input register is empty or draining this cycle
   assign req_ch.ready = !in_valid_ff || in_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_word_ff.pin_a      <= req_ch.pin_a;
         in_word_ff.pin_b      <= req_ch.pin_b;
         in_word_ff.click_edge <= req_ch.click_edge;
         in_word_ff.now_ms     <= req_ch.now_ms;
      end
   end

   // Hold the result word until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance) begin
         out_word_ff <= step_result;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.action      = out_word_ff.action;
   assign rsp_ch.scroll_time = out_word_ff.scroll_time;

endmodule
